>>> src/hrc_pkg.sv
// Shared types and constants of the heater regeneration controller.
package hrc_pkg;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_ON     = 2'd1,
      MODE_STABLE = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CSR_DUTY_PERCENT    = 3'd0,
      CSR_SURVEY_PERIOD   = 3'd1,
      CSR_TEMP_OFF        = 3'd2,
      CSR_CURRENT_BREAK   = 3'd3,
      CSR_CURRENT_SHORT   = 3'd4
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [6:0]         DUTY_RESET          = 7'd0;
   localparam logic [15:0]        SURVEY_PERIOD_RESET = 16'd1000;
   localparam logic signed [11:0] TEMP_OFF_RESET      = 12'sd1500;
   localparam logic [11:0]        BREAK_RESET         = 12'd10;
   localparam logic [11:0]        SHORT_RESET         = 12'd4000;

   localparam logic [1:0]  STABLE_PERIODS = 2'd2;
   localparam logic [1:0]  COUNT_MAX      = 2'd3;
   localparam logic [15:0] TIMER_MAX      = 16'hFFFF;

   typedef struct packed {
      logic              tick;
      logic              start_key;
      logic              stop_key;
      logic              interlock_busy;
      logic              heater_fault_present;
      logic              sensor_fault;
      logic signed [11:0] temperature;
      logic [11:0]       heater_current;
   } req_type;

   typedef struct packed {
      logic     heater_drive;
      logic     heater_active;
      logic [1:0] mode;
      logic     msg_started;
      logic     msg_stopped;
      logic     msg_finished;
      logic     msg_break;
      logic     msg_short;
      logic     msg_error_raised;
   } rsp_type;

   typedef struct packed {
      logic [6:0]         duty_percent;
      logic [15:0]        survey_period_ms;
      logic signed [11:0] temp_off_setpoint;
      logic [11:0]        current_break_setpoint;
      logic [11:0]        current_short_setpoint;
   } cfg_type;

endpackage

>>> src/hrc_csr.sv
// Configuration register file of the heater regeneration controller.
module hrc_csr
   import hrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DUTY_PERCENT:  cfg_in.duty_percent           = csr_wdata[6:0];
            CSR_SURVEY_PERIOD: cfg_in.survey_period_ms       = csr_wdata[15:0];
            CSR_TEMP_OFF:      cfg_in.temp_off_setpoint      = csr_wdata[11:0];
            CSR_CURRENT_BREAK: cfg_in.current_break_setpoint = csr_wdata[11:0];
            CSR_CURRENT_SHORT: cfg_in.current_short_setpoint = csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_percent           <= DUTY_RESET;
         cfg_ff.survey_period_ms       <= SURVEY_PERIOD_RESET;
         cfg_ff.temp_off_setpoint      <= TEMP_OFF_RESET;
         cfg_ff.current_break_setpoint <= BREAK_RESET;
         cfg_ff.current_short_setpoint <= SHORT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/hrc_core.sv
// Mode state machine, period timer and PWM decision for one request per step.
module hrc_core
   import hrc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   mode_type    mode_ff, mode_in;
   logic [15:0] timer_ff, timer_in;
   logic [1:0]  count_ff, count_in;

   logic [15:0] timer_tick;
   logic        hot, low_current, high_current;
   logic        running, switch_off, stabilize, wrap;
   logic [10:0] duty_x10;
   logic [1:0]  count_base;

   assign timer_tick   = (req.tick && timer_ff != TIMER_MAX) ? timer_ff + 16'd1 : timer_ff;
   assign hot          = req.temperature >= cfg.temp_off_setpoint;
   assign low_current  = req.heater_current <= cfg.current_break_setpoint;
   assign high_current = req.heater_current >= cfg.current_short_setpoint;
   assign running      = (mode_ff == MODE_ON) || (mode_ff == MODE_STABLE);
   assign switch_off   = req.stop_key || hot
                       || ((mode_ff == MODE_STABLE) && (low_current || high_current));

   // next state
   always_comb begin
      mode_in   = MODE_OFF;
      stabilize = 1'b0;
      unique case (mode_ff)
         MODE_ON: begin
            if (switch_off) begin
               mode_in = MODE_OFF;
            end else if (count_ff >= STABLE_PERIODS) begin
               mode_in   = MODE_STABLE;
               stabilize = 1'b1;
            end else begin
               mode_in = MODE_ON;
            end
         end
         MODE_STABLE: begin
            mode_in = switch_off ? MODE_OFF : MODE_STABLE;
         end
         default: begin
            if (req.start_key && !req.interlock_busy && !req.heater_fault_present
                && !req.sensor_fault) begin
               mode_in = MODE_ON;
            end
         end
      endcase
   end

   // timer wraps at the survey period; count periods only while on
   assign wrap       = timer_tick >= cfg.survey_period_ms;
   assign timer_in   = wrap ? 16'd0 : timer_tick;
   assign count_base = stabilize ? 2'd0 : count_ff;
   assign count_in   = (wrap && mode_in == MODE_ON && count_base != COUNT_MAX)
                       ? count_base + 2'd1 : count_base;

   // duty > timer/10 is the same as timer < duty*10
   assign duty_x10 = {1'b0, cfg.duty_percent, 3'b000} + {3'b000, cfg.duty_percent, 1'b0};

   // outputs
   always_comb begin
      rsp               = '0;
      rsp.mode          = mode_in;
      rsp.heater_active = (mode_in != MODE_OFF);
      rsp.heater_drive  = (mode_in != MODE_OFF) && (timer_tick < {5'd0, duty_x10});
      if (running) begin
         rsp.msg_finished = hot;
         rsp.msg_stopped  = req.stop_key;
         if (mode_ff == MODE_STABLE) begin
            rsp.msg_break        = low_current;
            rsp.msg_short        = high_current;
            rsp.msg_error_raised = low_current || high_current;
            rsp.msg_stopped      = req.stop_key || low_current || high_current;
         end
      end else begin
         rsp.msg_started = (mode_in == MODE_ON);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_OFF;
         timer_ff <= 16'd0;
         count_ff <= 2'd0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         timer_ff <= timer_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/heater_regeneration_controller.sv
// The result of an accepted request is registered in the result register.
// Throughput: one request per cycle while the result is not stalled; the state update is one pass of
// compare logic between the state registers and the result register.
// A stalled result holds; a new request is taken whenever the result
// register is empty or being taken in the same cycle.
// Reset (synchronous): mode off, timer and counter cleared, registers at defaults.
module heater_regeneration_controller
   import hrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   rsp_type step_rsp;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    accept;

   hrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hrc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept),
      .req     (req_data),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload loads only on a new request
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/hrc_checker.sv
// Port-level checks of the heater regeneration controller and their binding.
module hrc_checker
   import hrc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.heater_active == (rsp_data.mode != MODE_OFF))
                    && (!rsp_data.heater_drive || rsp_data.heater_active))
      else $error("active flag or pin disagrees with mode");

   a_error_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.msg_error_raised |->
         rsp_data.msg_stopped && (rsp_data.mode == MODE_OFF)
         && (rsp_data.msg_break || rsp_data.msg_short))
      else $error("error without stop");

   a_started: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.msg_started |->
         (rsp_data.mode == MODE_ON) && !rsp_data.msg_stopped)
      else $error("start message with wrong mode");

endmodule

bind heater_regeneration_controller hrc_checker u_hrc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
